[sv/signed_int_to_seven_segment_digits_macros.svh]
// Assertion macros for the signed_int_to_seven_segment_digits checker.
// Uses clk and rst from the scope where the macros are expanded.
`ifndef SIGNED_INT_TO_SEVEN_SEGMENT_DIGITS_MACROS_SVH
`define SIGNED_INT_TO_SEVEN_SEGMENT_DIGITS_MACROS_SVH

// same-cycle implication
`define SISD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sisd: same-cycle check failed");

// next-cycle implication
`define SISD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sisd: next-cycle check failed");

`endif

[sv/sisd_pkg.sv]
// Shared types, codes and the segment decoder for the seven-segment digit formatter.
// No dependencies.
package sisd_pkg;

  localparam int NUM_BCD       = 10;
  localparam int BITS_PER_CELL = 4;
  localparam int NUM_CELLS     = 32 / BITS_PER_CELL;
  localparam int DISP_POSITIONS = 10;

  localparam logic [3:0] CODE_MINUS        = 4'd10;
  localparam logic [3:0] CODE_BLANK        = 4'd11;
  localparam logic [3:0] DIGIT_COUNT_RESET = 4'd8;

  typedef struct packed {
    logic                    neg;
    logic [31:0]             bits;
    logic [NUM_BCD-1:0][3:0] bcd;
  } item_t;

  function automatic logic [6:0] seg_of(input logic [3:0] code);
    logic [6:0] s;
    unique case (code)
      4'd0:       s = 7'b1111110;
      4'd1:       s = 7'b0110000;
      4'd2:       s = 7'b1101101;
      4'd3:       s = 7'b1111001;
      4'd4:       s = 7'b0110011;
      4'd5:       s = 7'b1011011;
      4'd6:       s = 7'b1011111;
      4'd7:       s = 7'b1110000;
      4'd8:       s = 7'b1111111;
      4'd9:       s = 7'b1111011;
      CODE_MINUS: s = 7'b0000001;
      default:    s = 7'b0000000;
    endcase
    return s;
  endfunction

endpackage

[sv/signed_int_to_seven_segment_digits.sv]
// Signed 32-bit integer to seven-segment digits, top level.
// Depends on sisd_pkg, sisd_cell, sisd_fmt.
//
// Input channel: in_valid/in_ready with value, a two's complement integer.
// Output channel: out_valid/out_ready; each transfer carries one display
// position (leftmost first) with its digit code, segment pattern, overflow
// flag and last on the rightmost position.
// Config: cfg_wr_en writes cfg_wr_data into the digit count (positions in
// use, 0 acts as 1, above 10 acts as 10). Write only while idle.
// The magnitude is converted by a row of eight shift-add-3 cells, four bits
// each; the formatter register then offers the first result.
// Throughput: one result per cycle while out_ready is high; the cell row
// buffers up to eight further values meanwhile.
// Reset clears all valid flags and sets the digit count to 8.
// When the receiver stalls, the current result holds and the cells fill up,
// then in_ready drops.
module signed_int_to_seven_segment_digits
  import sisd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  position,
  output logic [3:0]  digit_code,
  output logic [6:0]  segments,
  output logic        overflow,
  output logic        last
);

  logic [3:0] digit_count;
  logic [3:0] used;

  logic  vld [NUM_CELLS+1];
  logic  rdy [NUM_CELLS+1];
  item_t itm [NUM_CELLS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= DIGIT_COUNT_RESET;
    end else if (cfg_wr_en) begin
      digit_count <= cfg_wr_data;
    end
  end

  always_comb begin
    if (digit_count == 4'd0) begin
      used = 4'd1;
    end else if (digit_count > 4'(DISP_POSITIONS)) begin
      used = 4'(DISP_POSITIONS);
    end else begin
      used = digit_count;
    end
  end

  assign vld[0]      = in_valid;
  assign in_ready    = rdy[0];
  assign itm[0].neg  = value[31];
  assign itm[0].bits = value[31] ? (32'd0 - value) : value;
  assign itm[0].bcd  = '0;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    sisd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (vld[k]),
      .up_ready (rdy[k]),
      .up_item  (itm[k]),
      .dn_valid (vld[k+1]),
      .dn_ready (rdy[k+1]),
      .dn_item  (itm[k+1])
    );
  end

  sisd_fmt u_fmt (
    .clk        (clk),
    .rst        (rst),
    .used       (used),
    .in_valid   (vld[NUM_CELLS]),
    .in_ready   (rdy[NUM_CELLS]),
    .in_item    (itm[NUM_CELLS]),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .position   (position),
    .digit_code (digit_code),
    .segments   (segments),
    .overflow   (overflow),
    .last       (last)
  );

endmodule

[sv/sisd_cell.sv]
// One conversion cell: shifts four binary bits into the BCD accumulator (shift-add-3).
// Depends on sisd_pkg.
module sisd_cell
  import sisd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  output logic  up_ready,
  input  item_t up_item,
  output logic  dn_valid,
  input  logic  dn_ready,
  output item_t dn_item
);

  item_t item_next;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    item_t t;
    t = up_item;
    for (int b = 0; b < BITS_PER_CELL; b++) begin
      for (int d = 0; d < NUM_BCD; d++) begin
        if (t.bcd[d] >= 4'd5) begin
          t.bcd[d] = t.bcd[d] + 4'd3;
        end
      end
      {t.bcd, t.bits} = {t.bcd, t.bits} << 1;
    end
    item_next = t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_item <= item_next;
    end
  end

endmodule

[sv/sisd_fmt.sv]
// Output formatter: holds one converted value and emits one position per cycle while out_ready is high.
// Depends on sisd_pkg.
module sisd_fmt
  import sisd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [3:0] used,
  input  logic       in_valid,
  output logic       in_ready,
  input  item_t      in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] position,
  output logic [3:0] digit_code,
  output logic [6:0] segments,
  output logic       overflow,
  output logic       last
);

  logic                    busy;
  logic [3:0]              idx;
  logic [3:0]              cnt;
  logic [3:0]              nd;
  logic                    neg;
  logic                    ovf;
  logic [NUM_BCD-1:0][3:0] bcd;

  logic [3:0] nd_next;
  logic       ovf_next;
  logic [3:0] from_right;

  always_comb begin
    nd_next = 4'd1;
    for (int d = 0; d < NUM_BCD; d++) begin
      if (in_item.bcd[d] != 4'd0) begin
        nd_next = 4'(d + 1);
      end
    end
    ovf_next = ({1'b0, nd_next} + {4'b0, in_item.neg}) > {1'b0, used};
  end

  assign last      = idx == (cnt - 4'd1);
  assign in_ready  = !busy || (out_ready && last);
  assign out_valid = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 4'd0;
    end else if (in_ready) begin
      busy <= in_valid;
      idx  <= 4'd0;
    end else if (out_ready) begin
      idx <= idx + 4'd1;
    end
    if (in_ready && in_valid) begin
      cnt <= used;
      nd  <= nd_next;
      neg <= in_item.neg;
      ovf <= ovf_next;
      bcd <= in_item.bcd;
    end
  end

  always_comb begin
    from_right = cnt - 4'd1 - idx;
    if (ovf) begin
      digit_code = CODE_MINUS;
    end else if (from_right < nd) begin
      digit_code = bcd[from_right];
    end else if (from_right == nd && neg) begin
      digit_code = CODE_MINUS;
    end else begin
      digit_code = CODE_BLANK;
    end
  end

  assign position = idx;
  assign segments = seg_of(digit_code);
  assign overflow = ovf;

endmodule

[sv/sisd_checker.sv]
// Port-level checks for signed_int_to_seven_segment_digits, bound to the top level.
// Depends on sisd_pkg and signed_int_to_seven_segment_digits_macros.svh.
`include "signed_int_to_seven_segment_digits_macros.svh"

module sisd_checker
  import sisd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  position,
  input logic [3:0]  digit_code,
  input logic [6:0]  segments,
  input logic        overflow,
  input logic        last
);

  `SISD_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
    out_valid && $stable(position) && $stable(digit_code) && $stable(last))
  `SISD_ASSERT_NEXT(a_pos_step, out_valid && out_ready && !last,
    out_valid && position == $past(position) + 4'd1)
  `SISD_ASSERT_NEXT(a_run_restart, out_valid && out_ready && last,
    !out_valid || position == 4'd0)
  `SISD_ASSERT_NOW(a_ovf_dash, out_valid && overflow,
    digit_code == CODE_MINUS && segments == seg_of(CODE_MINUS))

endmodule

bind signed_int_to_seven_segment_digits sisd_checker u_sisd_checker (.*);
